>>> src/reb_pkg.sv
package reb_pkg;

  // Highest acceleration level that growth may reach.
  localparam logic [11:0] ACCEL_TOP = 12'd3072;

  // Steps-per-notch settings that divide the count; any other value counts single steps.
  localparam logic [2:0] SPN_HALF    = 3'd2;
  localparam logic [2:0] SPN_QUARTER = 3'd4;

  typedef enum logic [1:0] {
    ACT_TICK        = 2'd0,
    ACT_READ_VALUE  = 2'd1,
    ACT_READ_BUTTON = 2'd2,
    ACT_NONE        = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    BTN_OPEN     = 3'd0,
    BTN_HELD     = 3'd1,
    BTN_RELEASED = 3'd2,
    BTN_CLICKED  = 3'd3,
    BTN_DOUBLE   = 3'd4
  } btn_state_e;

  typedef enum logic [2:0] {
    CFG_STEPS_PER_NOTCH     = 3'd0,
    CFG_DOUBLE_CLICK_ENABLE = 3'd1,
    CFG_ACCEL_ENABLE        = 3'd2,
    CFG_BUTTON_INTERVAL     = 3'd3,
    CFG_DOUBLE_CLICK_WINDOW = 3'd4,
    CFG_HOLD_LIMIT          = 3'd5,
    CFG_ACCEL_STEP_UP       = 3'd6,
    CFG_ACCEL_STEP_DOWN     = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0] steps_per_notch;
    logic       double_click_enable;
    logic       accel_enable;
    logic [7:0] button_interval;
    logic [7:0] double_click_window;
    logic [7:0] hold_limit;
    logic [7:0] accel_step_up;
    logic [7:0] accel_step_down;
  } cfg_t;

endpackage

>>> src/rotary_encoder_button_qualifier_unit.sv
// A transaction taken into the input register is applied when it advances from there, and
// the edge at which it advances also loads its result (if any) into the result register;
// m_axis_tvalid rises after that edge. Throughput: one transaction per cycle; a read waits
// only while an untaken result sits in the result register. Reset (rst_ni low, asynchronous)
// clears both stream stages, the encoder and button state, and loads every configuration
// register with its default.
module rotary_encoder_button_qualifier_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Input stream.
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [0] pin_a, [1] pin_b, [2] pin_button, [7:3] zero
  input  logic [1:0] s_axis_tuser,   // [1:0] action
  // Result stream.
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [4:0] value (signed), [7:5] button_state
  // Configuration write channel.
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);
  import reb_pkg::*;

  // Configuration registers. Writes are always taken; the user writes only while idle.
  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_STEPS_PER_NOTCH:     cfg_d.steps_per_notch     = cfg_data_i[2:0];
        CFG_DOUBLE_CLICK_ENABLE: cfg_d.double_click_enable = cfg_data_i[0];
        CFG_ACCEL_ENABLE:        cfg_d.accel_enable        = cfg_data_i[0];
        CFG_BUTTON_INTERVAL:     cfg_d.button_interval     = cfg_data_i;
        CFG_DOUBLE_CLICK_WINDOW: cfg_d.double_click_window = cfg_data_i;
        CFG_HOLD_LIMIT:          cfg_d.hold_limit          = cfg_data_i;
        CFG_ACCEL_STEP_UP:       cfg_d.accel_step_up       = cfg_data_i;
        CFG_ACCEL_STEP_DOWN:     cfg_d.accel_step_down     = cfg_data_i;
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.steps_per_notch     <= 3'd1;
      cfg_q.double_click_enable <= 1'b1;
      cfg_q.accel_enable        <= 1'b1;
      cfg_q.button_interval     <= 8'd30;
      cfg_q.double_click_window <= 8'd20;
      cfg_q.hold_limit          <= 8'd40;
      cfg_q.accel_step_up       <= 8'd25;
      cfg_q.accel_step_down     <= 8'd2;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Input register. The item held here is applied to the state in the cycle it advances,
  // and its result (if any) is captured in the result register at the same edge.
  logic       in_valid_q;
  action_e    in_action_q;
  logic       in_pin_a_q;
  logic       in_pin_b_q;
  logic       in_pin_button_q;

  logic       has_result;
  logic       out_free;
  logic       advance;
  logic       tick_en;
  logic       read_value_en;
  logic       read_button_en;

  logic signed [4:0] enc_value;
  btn_state_e        btn_state;

  logic       out_valid_q;
  logic [7:0] out_data_q;

  assign has_result = (in_action_q == ACT_READ_VALUE) || (in_action_q == ACT_READ_BUTTON);
  assign out_free   = !out_valid_q || m_axis_tready;
  // A tick or an empty action never waits on the result side.
  assign advance    = in_valid_q && (!has_result || out_free);
  assign s_axis_tready = !in_valid_q || advance;

  assign tick_en        = advance && (in_action_q == ACT_TICK);
  assign read_value_en  = advance && (in_action_q == ACT_READ_VALUE);
  assign read_button_en = advance && (in_action_q == ACT_READ_BUTTON);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_action_q     <= action_e'(s_axis_tuser);
      in_pin_a_q      <= s_axis_tdata[0];
      in_pin_b_q      <= s_axis_tdata[1];
      in_pin_button_q <= s_axis_tdata[2];
    end
  end

  reb_encoder u_encoder (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .tick_i  (tick_en),
    .read_i  (read_value_en),
    .pin_a_i (in_pin_a_q),
    .pin_b_i (in_pin_b_q),
    .value_o (enc_value)
  );

  reb_button u_button (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .tick_i       (tick_en),
    .read_i       (read_button_en),
    .pin_button_i (in_pin_button_q),
    .state_o      (btn_state)
  );

  // Result register. Reads see the state as it stood before the read's own update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && has_result) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (read_value_en) begin
      out_data_q <= {3'(BTN_OPEN), enc_value};
    end else if (read_button_en) begin
      out_data_q <= {3'(btn_state), 5'd0};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && has_result |=> m_axis_tvalid)
    else $error("result transaction not presented");

  a_read_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && has_result && m_axis_tvalid && !m_axis_tready |=> in_valid_q)
    else $error("read transaction dropped while result stalled");

  a_tick_never_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !has_result |-> s_axis_tready)
    else $error("tick transaction blocked the input stream");

endmodule

>>> src/reb_encoder.sv
module reb_encoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  reb_pkg::cfg_t      cfg_i,
  input  logic               tick_i,
  input  logic               read_i,
  input  logic               pin_a_i,
  input  logic               pin_b_i,
  output logic signed [4:0]  value_o
);
  import reb_pkg::*;

  logic [1:0]  phase_q, phase_d;
  logic [15:0] count_q, count_d;
  logic [11:0] accel_q, accel_d;

  logic [11:0] accel_dec;
  logic [1:0]  curr_phase;
  logic [1:0]  phase_diff;
  logic        moved;
  logic [12:0] grow_sum;
  logic        can_grow;
  logic [3:0]  mag_add;
  logic [3:0]  mag;
  logic [15:0] thresh;

  always_comb begin
    accel_dec  = (accel_q < {4'd0, cfg_i.accel_step_down}) ? 12'd0
                 : accel_q - {4'd0, cfg_i.accel_step_down};
    // Gray phase from the active-low pins.
    curr_phase = {~pin_b_i, pin_a_i ^ pin_b_i};
    phase_diff = phase_q - curr_phase;
    moved      = phase_diff[0];
    grow_sum   = {1'b0, accel_dec} + {5'd0, cfg_i.accel_step_up};
    can_grow   = (grow_sum <= {1'b0, ACCEL_TOP});

    phase_d = phase_q;
    count_d = count_q;
    accel_d = accel_q;
    if (tick_i) begin
      if (cfg_i.accel_enable) begin
        accel_d = accel_dec;
      end
      if (moved) begin
        phase_d = curr_phase;
        count_d = phase_diff[1] ? count_q + 16'd1 : count_q - 16'd1;
      end
      if (cfg_i.accel_enable && moved && can_grow) begin
        accel_d = grow_sum[11:0];
      end
    end
    if (read_i) begin
      if (cfg_i.steps_per_notch == SPN_HALF) begin
        count_d = {15'd0, count_q[0]};
      end else if (cfg_i.steps_per_notch == SPN_QUARTER) begin
        count_d = {14'd0, count_q[1:0]};
      end else begin
        count_d = 16'd0;
      end
    end
  end

  // Notch value seen from the current count and acceleration.
  always_comb begin
    mag_add = cfg_i.accel_enable ? accel_q[11:8] : 4'd0;
    mag     = (mag_add == 4'hF) ? 4'hF : mag_add + 4'd1;
    if (cfg_i.steps_per_notch == SPN_HALF) begin
      thresh = 16'd2;
    end else if (cfg_i.steps_per_notch == SPN_QUARTER) begin
      thresh = 16'd4;
    end else begin
      thresh = 16'd1;
    end
    if (count_q[15]) begin
      value_o = $signed(5'd0 - {1'b0, mag});
    end else if (count_q >= thresh) begin
      value_o = $signed({1'b0, mag});
    end else begin
      value_o = 5'sd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
      count_q <= 16'd0;
      accel_q <= 12'd0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      accel_q <= accel_d;
    end
  end

  // Growth is gated so that the level can never pass the top.
  a_accel_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accel_q <= ACCEL_TOP)
    else $error("acceleration level above top");

endmodule

>>> src/reb_button.sv
module reb_button (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  reb_pkg::cfg_t       cfg_i,
  input  logic                tick_i,
  input  logic                read_i,
  input  logic                pin_button_i,
  output reb_pkg::btn_state_e state_o
);
  import reb_pkg::*;

  logic [7:0] tsc_q, tsc_d;
  logic [7:0] pc_q, pc_d;
  logic [7:0] cc_q, cc_d;
  btn_state_e ev_q, ev_d;

  logic [7:0] tsc_inc;
  logic       check;
  logic [7:0] pc_inc;

  always_comb begin
    tsc_inc = (tsc_q == 8'hFF) ? tsc_q : tsc_q + 8'd1;
    check   = (tsc_inc >= cfg_i.button_interval);
    pc_inc  = (pc_q == 8'hFF) ? pc_q : pc_q + 8'd1;

    tsc_d = tsc_q;
    pc_d  = pc_q;
    cc_d  = cc_q;
    ev_d  = ev_q;
    if (tick_i) begin
      tsc_d = check ? 8'd0 : tsc_inc;
      if (check) begin
        if (!pin_button_i) begin
          pc_d = pc_inc;
          if (pc_inc > cfg_i.hold_limit) begin
            ev_d = BTN_HELD;
          end
        end else begin
          if (pc_q != 8'd0) begin
            if (ev_q == BTN_HELD) begin
              ev_d = BTN_RELEASED;
              cc_d = 8'd0;
            end else if (cc_q > 8'd1) begin
              if (cc_q < cfg_i.double_click_window) begin
                ev_d = BTN_DOUBLE;
                cc_d = 8'd0;
              end
            end else if (cfg_i.double_click_enable) begin
              cc_d = (cfg_i.double_click_window != 8'd0) ? cfg_i.double_click_window : 8'd1;
            end else begin
              cc_d = 8'd1;
            end
          end
          pc_d = 8'd0;
        end
        // One countdown step per check; the click is reported when it runs out.
        if (cc_d != 8'd0) begin
          cc_d = cc_d - 8'd1;
          if (cc_d == 8'd0) begin
            ev_d = BTN_CLICKED;
          end
        end
      end
    end
    if (read_i && (ev_q != BTN_HELD)) begin
      ev_d = BTN_OPEN;
    end
  end

  assign state_o = ev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tsc_q <= 8'd0;
      pc_q  <= 8'd0;
      cc_q  <= 8'd0;
      ev_q  <= BTN_OPEN;
    end else begin
      tsc_q <= tsc_d;
      pc_q  <= pc_d;
      cc_q  <= cc_d;
      ev_q  <= ev_d;
    end
  end

endmodule

>>> bench/tb.sv
module tb;
  import reb_pkg::*;

  // One entry of the stimulus queue. A marker entry carries no transaction; it makes the
  // driver pause until every readout that is still expected has come back.
  typedef struct {
    action_e act;
    bit      pa;
    bit      pb;
    bit      btn;
    bit      marker;
  } enc_item_t;

  typedef struct {
    logic signed [4:0] value;
    btn_state_e        state;
  } readout_t;

  localparam int NUM_SETTINGS = 7;
  localparam int ITEMS_PER_SETTING = 80;
  localparam int LONG_HOLD = 150;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'd0;
  logic [1:0] s_axis_tuser = 2'd0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [2:0] cfg_index_i = 3'd0;
  logic [7:0] cfg_data_i = 8'd0;

  rotary_encoder_button_qualifier_unit i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  enc_item_t pending_inputs[$];
  readout_t  expected_readouts[$];

  // Predicted configuration and encoder/button state, reset values included.
  // Field order: steps, dbl enable, accel enable, interval, window, hold, up, down.
  cfg_t              model_cfg = {3'd1, 1'b1, 1'b1, 8'd30, 8'd20, 8'd40, 8'd25, 8'd2};
  logic [1:0]        last_phase = 2'd0;
  logic [15:0]       step_count = 16'd0;
  logic [11:0]       accel_level = 12'd0;
  logic [7:0]        ticks_since_check = 8'd0;
  logic [7:0]        pressed_checks = 8'd0;
  logic [7:0]        click_countdown = 8'd0;
  btn_state_e        button_event = BTN_OPEN;

  int        errors = 0;
  int        n_ticks = 0;
  int        n_reads = 0;
  int        n_readouts = 0;
  int        queued = 0;
  int        tx_gap = 0;
  int        rx_stall = 0;
  bit        tx_burst = 1'b0;
  bit        rx_burst = 1'b0;
  bit        hold_request = 1'b0;
  bit        hold_done = 1'b0;
  enc_item_t offered;

  // Stimulus-side view of the knob position and the button level.
  logic [1:0] enc_pos = 2'd0;
  bit         btn_level = 1'b1;

  // Advances the predicted state by one accepted transaction and queues the readout it causes.
  function automatic void encoder_predict(enc_item_t it);
    logic [1:0]        curr;
    logic [1:0]        diff;
    logic signed [15:0] signed_count;
    bit                moved;
    int                mag;
    int                thresh;
    readout_t          r;
    case (it.act)
      ACT_TICK: begin
        n_ticks++;
        if (model_cfg.accel_enable) begin
          accel_level = (accel_level < model_cfg.accel_step_down) ? 12'd0 :
                        accel_level - 12'(model_cfg.accel_step_down);
        end
        curr = it.pb ? 2'd0 : 2'd3;
        if (!it.pa) curr = curr ^ 2'd1;
        diff = last_phase - curr;
        moved = diff[0];
        if (moved) begin
          last_phase = curr;
          step_count = step_count + (diff[1] ? 16'd1 : 16'hFFFF);
        end
        // Growth is taken only where it keeps the level at or below the top.
        if (model_cfg.accel_enable && moved &&
            int'(accel_level) <= int'(ACCEL_TOP) - int'(model_cfg.accel_step_up)) begin
          accel_level = accel_level + 12'(model_cfg.accel_step_up);
        end
        if (ticks_since_check < 8'd255) ticks_since_check++;
        if (ticks_since_check >= model_cfg.button_interval) begin
          ticks_since_check = 8'd0;
          if (!it.btn) begin
            if (pressed_checks < 8'd255) pressed_checks++;
            if (pressed_checks > model_cfg.hold_limit) button_event = BTN_HELD;
          end else begin
            if (pressed_checks != 8'd0) begin
              if (button_event == BTN_HELD) begin
                button_event = BTN_RELEASED;
                click_countdown = 8'd0;
              end else if (click_countdown > 8'd1) begin
                if (click_countdown < model_cfg.double_click_window) begin
                  button_event = BTN_DOUBLE;
                  click_countdown = 8'd0;
                end
              end else if (model_cfg.double_click_enable) begin
                // A zero window behaves as one, so the click is reported at once.
                click_countdown = (model_cfg.double_click_window != 8'd0) ?
                                  model_cfg.double_click_window : 8'd1;
              end else begin
                click_countdown = 8'd1;
              end
            end
            pressed_checks = 8'd0;
          end
          if (click_countdown > 8'd0) begin
            click_countdown--;
            if (click_countdown == 8'd0) button_event = BTN_CLICKED;
          end
        end
      end
      ACT_READ_VALUE: begin
        n_reads++;
        signed_count = step_count;
        if (model_cfg.steps_per_notch == SPN_HALF) begin
          step_count = step_count & 16'd1;
          thresh = 2;
        end else if (model_cfg.steps_per_notch == SPN_QUARTER) begin
          step_count = step_count & 16'd3;
          thresh = 4;
        end else begin
          step_count = 16'd0;
          thresh = 1;
        end
        mag = 1 + (model_cfg.accel_enable ? int'(accel_level >> 8) : 0);
        if (mag > 15) mag = 15;
        if (signed_count < 0) r.value = 5'(-mag);
        else if (int'(signed_count) >= thresh) r.value = 5'(mag);
        else r.value = 5'd0;
        r.state = BTN_OPEN;
        expected_readouts.push_back(r);
      end
      ACT_READ_BUTTON: begin
        n_reads++;
        r.value = 5'd0;
        r.state = button_event;
        // A held button stays reported until it is let go.
        if (button_event != BTN_HELD) button_event = BTN_OPEN;
        expected_readouts.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // Mostly short gaps, a few long ones, none at all while a burst is running.
  function automatic int idle_span(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void queue_item(action_e act, bit pa, bit pb, bit btn);
    enc_item_t it;
    it.act = act;
    it.pa = pa;
    it.pb = pb;
    it.btn = btn;
    it.marker = 1'b0;
    pending_inputs.push_back(it);
    if (act != ACT_NONE) queued++;
  endfunction

  // One sample at the current knob position: phases 0..3 map to (A,B) = 11, 01, 00, 10.
  function automatic void queue_tick();
    queue_item(ACT_TICK, ~(enc_pos[0] ^ enc_pos[1]), ~enc_pos[1], btn_level);
  endfunction

  function automatic void queue_marker();
    enc_item_t it;
    it.act = ACT_TICK;
    it.pa = 1'b1;
    it.pb = 1'b1;
    it.btn = 1'b1;
    it.marker = 1'b1;
    pending_inputs.push_back(it);
  endfunction

  // Random gestures: turns, short and long presses, reads and some noise.
  function automatic void queue_gestures(int count);
    int  stop;
    int  len;
    int  choice;
    bit  dir;
    bit  marked;
    stop = queued + count;
    marked = 1'b0;
    while (queued < stop) begin
      choice = $urandom_range(0, 9);
      if (choice <= 3) begin
        dir = 1'($urandom_range(0, 1));
        len = $urandom_range(1, 8);
        repeat (len) begin
          enc_pos = dir ? enc_pos + 2'd1 : enc_pos - 2'd1;
          queue_tick();
        end
      end else if (choice <= 6) begin
        btn_level = 1'b0;
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
        repeat (len) begin
          queue_tick();
          if ($urandom_range(0, 7) == 0) queue_item(ACT_READ_BUTTON, 1'b1, 1'b1, 1'b1);
        end
        btn_level = 1'b1;
        len = ($urandom_range(0, 2) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 6);
        repeat (len) queue_tick();
      end else if (choice == 7) begin
        queue_item($urandom_range(0, 1) ? ACT_READ_VALUE : ACT_READ_BUTTON,
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
      end else if (choice == 8) begin
        repeat ($urandom_range(1, 4)) begin
          queue_item(action_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
      end else begin
        repeat ($urandom_range(5, 30)) queue_tick();
      end
      if ($urandom_range(0, 1) == 0) queue_item(ACT_READ_BUTTON, 1'b1, 1'b1, 1'b1);
      if ($urandom_range(0, 1) == 0) queue_item(ACT_READ_VALUE, 1'b1, 1'b1, 1'b1);
      if (!marked && queued >= stop - count / 2) begin
        queue_marker();
        marked = 1'b1;
      end
    end
  endfunction

  // Input driver: offers the queued transactions with random gaps between them.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= 8'd0;
      s_axis_tuser <= 2'd0;
      tx_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        encoder_predict(offered);
        if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
        tx_gap = idle_span(tx_burst);
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_inputs.size() > 0 && !pending_inputs[0].marker) begin
          offered = pending_inputs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {5'd0, offered.btn, offered.pb, offered.pa};
          s_axis_tuser <= offered.act;
        end else begin
          if (pending_inputs.size() > 0 && expected_readouts.size() == 0) begin
            void'(pending_inputs.pop_front());
          end
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result-side ready: short random stalls, plus one long hold-off on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        rx_stall = LONG_HOLD;
      end
      if ($urandom_range(0, 63) == 0) rx_burst = !rx_burst;
      if (rx_stall > 0) begin
        rx_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        rx_stall = ($urandom_range(0, 3) == 0) ? idle_span(rx_burst) : 0;
        m_axis_tready <= (rx_stall == 0);
      end
    end
  end

  // Result monitor: each readout transaction is checked against the oldest prediction.
  always @(posedge clk_i) begin : check_readouts
    readout_t          exp_r;
    logic signed [4:0] got_value;
    logic [2:0]        got_state;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_value = m_axis_tdata[4:0];
      got_state = m_axis_tdata[7:5];
      n_readouts++;
      if (expected_readouts.size() == 0) begin
        $display("[%0t] unexpected readout: value %0d, button state %0d",
                 $time, got_value, got_state);
        errors++;
      end else begin
        exp_r = expected_readouts.pop_front();
        if (got_value !== exp_r.value) begin
          $display("[%0t] value mismatch: expected %0d, actual %0d",
                   $time, exp_r.value, got_value);
          errors++;
        end
        if (got_state !== exp_r.state) begin
          $display("[%0t] button state mismatch: expected %0d, actual %0d",
                   $time, exp_r.state, got_state);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_STEPS_PER_NOTCH:     model_cfg.steps_per_notch = data[2:0];
      CFG_DOUBLE_CLICK_ENABLE: model_cfg.double_click_enable = data[0];
      CFG_ACCEL_ENABLE:        model_cfg.accel_enable = data[0];
      CFG_BUTTON_INTERVAL:     model_cfg.button_interval = data;
      CFG_DOUBLE_CLICK_WINDOW: model_cfg.double_click_window = data;
      CFG_HOLD_LIMIT:          model_cfg.hold_limit = data;
      CFG_ACCEL_STEP_UP:       model_cfg.accel_step_up = data;
      default:                 model_cfg.accel_step_down = data;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Waits until the driver has nothing left and every readout is back; ticks give no readout,
  // so a further wait lets them pass the two-stage pipeline. The driver may have taken its last
  // transaction in the same step as the first check, so readouts are awaited once more.
  task automatic wait_idle();
    while (pending_inputs.size() > 0 || s_axis_tvalid || expected_readouts.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (6) @(posedge clk_i);
    while (expected_readouts.size() > 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    cfg_t settings[NUM_SETTINGS];
    cfg_t c;
    // Field order: steps, dbl enable, accel enable, interval, window, hold, up, down.
    settings[0] = {3'd1, 1'b1, 1'b1, 8'd1,   8'd4,   8'd3,   8'd25,  8'd2};
    settings[1] = {3'd2, 1'b1, 1'b1, 8'd2,   8'd6,   8'd5,   8'd255, 8'd0};
    settings[2] = {3'd4, 1'b0, 1'b1, 8'd1,   8'd2,   8'd1,   8'd200, 8'd255};
    settings[3] = {3'd3, 1'b1, 1'b0, 8'd3,   8'd255, 8'd254, 8'd0,   8'd1};
    // Interval zero checks on every tick; window zero reports a click at once.
    settings[4] = {3'd0, 1'b1, 1'b1, 8'd0,   8'd0,   8'd2,   8'd100, 8'd7};
    settings[5] = {3'd7, 1'b1, 1'b1, 8'd255, 8'd3,   8'd1,   8'd25,  8'd2};
    settings[6] = {3'd1, 1'b1, 1'b1, 8'd1,   8'd5,   8'd4,   8'd255, 8'd0};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed start under the reset settings.
    queue_item(ACT_READ_VALUE, 1'b1, 1'b1, 1'b1);
    queue_item(ACT_READ_BUTTON, 1'b1, 1'b1, 1'b1);
    queue_item(ACT_NONE, 1'b0, 1'b0, 1'b0);
    queue_item(ACT_TICK, 1'b0, 1'b1, 1'b1);   // forward through all four phases
    queue_item(ACT_TICK, 1'b0, 1'b0, 1'b1);
    queue_item(ACT_TICK, 1'b1, 1'b0, 1'b1);
    queue_item(ACT_TICK, 1'b1, 1'b1, 1'b1);
    queue_item(ACT_READ_VALUE, 1'b1, 1'b1, 1'b1);
    queue_item(ACT_TICK, 1'b1, 1'b0, 1'b1);   // two steps backward
    queue_item(ACT_TICK, 1'b0, 1'b0, 1'b1);
    queue_item(ACT_READ_VALUE, 1'b1, 1'b1, 1'b1);
    queue_item(ACT_TICK, 1'b1, 1'b1, 1'b1);   // half-turn jumps are not steps
    queue_item(ACT_TICK, 1'b0, 1'b0, 1'b1);
    queue_item(ACT_TICK, 1'b0, 1'b0, 1'b0);
    queue_item(ACT_TICK, 1'b0, 1'b0, 1'b0);
    queue_item(ACT_TICK, 1'b0, 1'b0, 1'b0);
    queue_item(ACT_READ_BUTTON, 1'b0, 1'b0, 1'b0);
    queue_item(ACT_READ_VALUE, 1'b0, 1'b0, 1'b0);
    queue_item(ACT_TICK, 1'b0, 1'b0, 1'b1);
    queue_item(ACT_READ_BUTTON, 1'b1, 1'b1, 1'b1);
    queue_item(ACT_NONE, 1'b1, 1'b1, 1'b1);
    enc_pos = 2'd2;
    btn_level = 1'b1;
    wait_idle();

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      c = settings[s];
      write_reg(CFG_STEPS_PER_NOTCH, {5'd0, c.steps_per_notch});
      write_reg(CFG_DOUBLE_CLICK_ENABLE, {7'd0, c.double_click_enable});
      write_reg(CFG_ACCEL_ENABLE, {7'd0, c.accel_enable});
      write_reg(CFG_BUTTON_INTERVAL, c.button_interval);
      write_reg(CFG_DOUBLE_CLICK_WINDOW, c.double_click_window);
      write_reg(CFG_HOLD_LIMIT, c.hold_limit);
      write_reg(CFG_ACCEL_STEP_UP, c.accel_step_up);
      write_reg(CFG_ACCEL_STEP_DOWN, c.accel_step_down);
      // Under the second setting the result side holds off long enough to back up the input.
      if (s == 1) hold_request = 1'b1;
      queue_gestures(ITEMS_PER_SETTING);
      wait_idle();
    end

    $display("Sent %0d transactions (%0d ticks, %0d reads) under %0d register settings;",
             queued, n_ticks, n_reads, NUM_SETTINGS + 1);
    $display("checked %0d readouts, %0d mismatches.", n_readouts, errors);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #3200000;
    $display("Timed out with %0d transactions pending and %0d readouts outstanding.",
             pending_inputs.size(), expected_readouts.size());
    $display("tb: done, errors");
    $finish;
  end

endmodule
